// ===== src/fta_pkg.sv =====
`timescale 1ns / 1ps
package fta_pkg;

    // Field widths of one request and one stored entry.
    localparam int KEY_W  = 17;
    localparam int PORT_W = 16;
    localparam int FAM_W  = 8;
    localparam int ADDR_W = 64;
    localparam int PROC_W = 32;
    localparam int TIME_W = 63;
    localparam int META_W = 56;
    localparam int TTL_W  = 17;
    localparam int SPAN_W = 41;

    // Hash and aging constants.
    localparam logic [31:0]      HASH_MUL      = 32'd2654435769;
    localparam logic [31:0]      UDP_FOLD      = 32'hA5A5A5A5;
    localparam logic [23:0]      TICKS_PER_SEC = 24'd10000000;
    localparam logic [TTL_W-1:0] TTL_RESET     = 17'd300;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_SWEEP  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_SPACE  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        F_IDLE,
        F_HASH,
        F_RECIP,
        F_MOD,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_EXEC,
        B_SPAN,
        B_CUT,
        B_SW_RD,
        B_SW_WR,
        B_DONE
    } t_back_state;

    // One request as it travels from the front to the back.
    typedef struct packed {
        t_func              func;
        logic [KEY_W-1:0]   key;
        logic [FAM_W-1:0]   fam;
        logic [ADDR_W-1:0]  ahi;
        logic [ADDR_W-1:0]  alo;
        logic [PORT_W-1:0]  dport;
        logic [PROC_W-1:0]  proc_id;
        logic [TIME_W-1:0]  now;
    } t_cmd;

    // One slot of a bucket row; meta is family, port, process id from the top.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [ADDR_W-1:0]  ahi;
        logic [ADDR_W-1:0]  alo;
        logic [META_W-1:0]  meta;
        logic [TIME_W-1:0]  created;
    } t_entry;

    // Result payload; the family sits in the lowest bits.
    typedef struct packed {
        logic [PROC_W-1:0]  proc_id;
        logic [PORT_W-1:0]  port;
        logic [ADDR_W-1:0]  alo;
        logic [ADDR_W-1:0]  ahi;
        logic [FAM_W-1:0]   fam;
    } t_result;

    localparam int CMD_W   = $bits(t_cmd);
    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== src/fta_ram.sv =====
`timescale 1ns / 1ps
module fta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fta_queue.sv =====
`timescale 1ns / 1ps
module fta_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/fta_front.sv =====
`timescale 1ns / 1ps
module fta_front #(
    parameter int BUCKETS = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_enable,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  fta_pkg::t_cmd                           i_cmd,
    output logic                                    o_q_push,
    output logic [$clog2(BUCKETS)+fta_pkg::CMD_W-1:0] o_q_data,
    input  logic                                    i_q_full
);
    import fta_pkg::*;

    localparam int BKT_W = $clog2(BUCKETS);
    localparam logic [31:0]    BKT_C = 32'(BUCKETS);
    localparam logic [31:0]    RECIP = 32'((64'd1 << 32) / BUCKETS);
    localparam logic [BKT_W:0] B_EXT = (BKT_W + 1)'(BUCKETS);

    t_front_state r_state, n_state;
    t_cmd         r_cmd;
    logic [31:0]  r_h;
    logic [31:0]  r_q;
    logic [BKT_W:0] r_rem;

    logic [47:0]    w_hash_full;
    logic [63:0]    w_recip_full;
    logic [63:0]    w_qb_full;
    logic [31:0]    w_diff;
    logic [BKT_W:0] w_bkt_ext;

    // Hash, reciprocal quotient estimate and remainder, one product per cycle.
    assign w_hash_full  = {32'd0, r_cmd.key[KEY_W-1:1]} * {16'd0, HASH_MUL};
    assign w_recip_full = {32'd0, r_h} * {32'd0, RECIP};
    assign w_qb_full    = {32'd0, r_q} * {32'd0, BKT_C};
    assign w_diff       = r_h - w_qb_full[31:0];
    // The quotient estimate is low by at most one, so one correction suffices.
    assign w_bkt_ext    = (r_rem >= B_EXT) ? (r_rem - B_EXT) : r_rem;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_in_valid && i_enable) n_state = F_HASH;
            F_HASH:  n_state = F_RECIP;
            F_RECIP: n_state = F_MOD;
            F_MOD:   n_state = F_PUSH;
            F_PUSH:  if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready = 1'b0;
        o_q_push   = 1'b0;
        case (r_state)
            F_IDLE:  o_in_ready = i_enable;
            F_PUSH:  o_q_push   = !i_q_full;
            default: begin
                o_in_ready = 1'b0;
                o_q_push   = 1'b0;
            end
        endcase
    end

    assign o_q_data = {w_bkt_ext[BKT_W-1:0], r_cmd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= i_cmd;
        end
        if (r_state == F_HASH) begin
            r_h <= w_hash_full[31:0] ^ (r_cmd.key[0] ? UDP_FOLD : 32'd0);
        end
        if (r_state == F_RECIP) begin
            r_q <= w_recip_full[63:32];
        end
        if (r_state == F_MOD) begin
            r_rem <= w_diff[BKT_W:0];
        end
    end

endmodule

// ===== src/fta_back.sv =====
`timescale 1ns / 1ps
module fta_back #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic [fta_pkg::TTL_W-1:0]                 i_ttl,
    input  logic                                      i_q_empty,
    input  logic [$clog2(BUCKETS)+fta_pkg::CMD_W-1:0] i_q_data,
    output logic                                      o_q_pop,
    output logic                                      o_busy,
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output fta_pkg::t_status                          o_out_status,
    output fta_pkg::t_result                          o_out_data
);
    import fta_pkg::*;

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * ENTRY_W;
    localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(BUCKETS - 1);

    t_back_state         r_state, n_state;
    logic [BKT_W-1:0]    r_cnt;
    t_cmd                r_cmd;
    logic [BKT_W-1:0]    r_bkt;
    logic [SPAN_W-1:0]   r_span;
    logic [TIME_W-1:0]   r_cutoff;
    logic                r_out_valid;
    t_status             r_out_status;
    t_result             r_out_data;

    t_cmd             w_head_cmd;
    logic [BKT_W-1:0] w_head_bkt;
    logic             w_out_free;
    logic [TIME_W-1:0] w_span_ext;
    logic             w_cut_ok;

    logic             w_re;
    logic [BKT_W-1:0] w_raddr;
    logic             w_row_we;
    logic [ROW_W-1:0] w_row_wd;
    logic [ROW_W-1:0] w_row_rd;
    logic             w_vld_we;
    logic [BKT_W-1:0] w_vld_waddr;
    logic [WAYS-1:0]  w_vld_wd;
    logic [WAYS-1:0]  w_vld_rd;

    t_entry           w_ent [WAYS];
    t_entry           w_new;
    logic [WAYS-1:0]  w_match;
    logic [WAYS-1:0]  w_old;
    logic             w_hit;
    logic             w_free;
    logic [WAY_W-1:0] w_hit_idx;
    logic [WAY_W-1:0] w_free_idx;
    logic [WAY_W-1:0] w_ins_idx;
    logic [WAYS-1:0]  w_ins_mask;
    logic [ROW_W-1:0] w_ins_row;

    logic             w_res_load;
    t_status          w_res_status;
    t_result          w_res_data;

    assign w_head_cmd = t_cmd'(i_q_data[CMD_W-1:0]);
    assign w_head_bkt = i_q_data[CMD_W +: BKT_W];
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_span_ext = TIME_W'(r_span);
    assign w_cut_ok   = (r_cmd.now >= w_span_ext);

    // Bucket rows and their valid bits.
    fta_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (r_bkt),
        .i_wdata (w_row_wd),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_row_rd)
    );

    fta_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_vld_ram (
        .i_clk   (i_clk),
        .i_we    (w_vld_we),
        .i_waddr (w_vld_waddr),
        .i_wdata (w_vld_wd),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_vld_rd)
    );

    // Per-way compare against the key and the aging cutoff.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_ent[w]   = t_entry'(w_row_rd[w*ENTRY_W +: ENTRY_W]);
            w_match[w] = w_vld_rd[w] && (w_ent[w].key == r_cmd.key);
            w_old[w]   = w_vld_rd[w] && (w_ent[w].created < r_cutoff);
        end
    end

    // Lowest matching way and lowest free way.
    always_comb begin
        w_hit      = 1'b0;
        w_free     = 1'b0;
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_match[w]) begin
                w_hit     = 1'b1;
                w_hit_idx = WAY_W'(w);
            end
            if (!w_vld_rd[w]) begin
                w_free     = 1'b1;
                w_free_idx = WAY_W'(w);
            end
        end
    end

    // Insert target and the rewritten row.
    assign w_ins_idx     = w_hit ? w_hit_idx : w_free_idx;
    assign w_new.key     = r_cmd.key;
    assign w_new.ahi     = r_cmd.ahi;
    assign w_new.alo     = r_cmd.alo;
    assign w_new.meta    = {r_cmd.fam, r_cmd.dport, r_cmd.proc_id};
    assign w_new.created = r_cmd.now;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_ins_mask[w] = (WAY_W'(w) == w_ins_idx);
            w_ins_row[w*ENTRY_W +: ENTRY_W] = w_ins_mask[w] ? w_new : w_ent[w];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: if (r_cnt == LAST_BKT) n_state = B_IDLE;
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (w_head_cmd.func == FUNC_SWEEP) ? B_SPAN : B_EXEC;
                end
            end
            B_EXEC:  if (w_out_free) n_state = B_IDLE;
            B_SPAN:  n_state = B_CUT;
            B_CUT:   n_state = w_cut_ok ? B_SW_RD : B_DONE;
            B_SW_RD: n_state = B_SW_WR;
            B_SW_WR: n_state = (r_cnt == LAST_BKT) ? B_DONE : B_SW_RD;
            B_DONE:  if (w_out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Memory controls and result load.
    always_comb begin
        o_q_pop      = 1'b0;
        w_re         = 1'b0;
        w_raddr      = r_cnt;
        w_row_we     = 1'b0;
        w_row_wd     = w_ins_row;
        w_vld_we     = 1'b0;
        w_vld_waddr  = r_bkt;
        w_vld_wd     = w_vld_rd;
        w_res_load   = 1'b0;
        w_res_status = ST_OK;
        w_res_data   = '0;
        case (r_state)
            B_CLEAR: begin
                w_vld_we    = 1'b1;
                w_vld_waddr = r_cnt;
                w_vld_wd    = '0;
            end
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    w_re    = (w_head_cmd.func != FUNC_SWEEP);
                    w_raddr = w_head_bkt;
                end
            end
            B_EXEC: begin
                if (w_out_free) begin
                    w_res_load = 1'b1;
                    case (r_cmd.func)
                        FUNC_INSERT: begin
                            if (w_hit || w_free) begin
                                w_row_we = 1'b1;
                                w_vld_we = 1'b1;
                                w_vld_wd = w_vld_rd | w_ins_mask;
                            end else begin
                                w_res_status = ST_NO_SPACE;
                            end
                        end
                        FUNC_LOOKUP: begin
                            if (w_hit) begin
                                w_res_data.fam     = w_ent[w_hit_idx].meta[55:48];
                                w_res_data.ahi     = w_ent[w_hit_idx].ahi;
                                w_res_data.alo     = w_ent[w_hit_idx].alo;
                                w_res_data.port    = w_ent[w_hit_idx].meta[47:32];
                                w_res_data.proc_id = w_ent[w_hit_idx].meta[31:0];
                            end else begin
                                w_res_status = ST_NOT_FOUND;
                            end
                        end
                        FUNC_REMOVE: begin
                            w_vld_we = 1'b1;
                            w_vld_wd = w_vld_rd & ~w_match;
                        end
                        default: w_res_status = ST_OK;
                    endcase
                end
            end
            B_SW_RD: begin
                w_re = 1'b1;
            end
            B_SW_WR: begin
                w_vld_we    = 1'b1;
                w_vld_waddr = r_cnt;
                w_vld_wd    = w_vld_rd & ~w_old;
            end
            B_DONE: begin
                w_res_load = w_out_free;
            end
            default: w_res_load = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR || r_state == B_SW_WR) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (r_state == B_CUT) begin
                r_cnt <= '0;
            end
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request, aging cutoff and result payload.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= w_head_cmd;
            r_bkt <= w_head_bkt;
        end
        if (r_state == B_SPAN) begin
            r_span <= SPAN_W'(i_ttl) * SPAN_W'(TICKS_PER_SEC);
        end
        if (r_state == B_CUT) begin
            r_cutoff <= r_cmd.now - w_span_ext;
        end
        if (w_res_load) begin
            r_out_status <= w_res_status;
            r_out_data   <= w_res_data;
        end
    end

    assign o_busy       = (r_state == B_CLEAR);
    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out_data;

    // A pop only takes a queued request.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !i_q_empty)
        else $error("request popped from empty queue");

    // No request is taken while the valid bits are being cleared.
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !o_q_pop)
        else $error("request popped during clearing pass");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

    // The row memory is only written while an insert completes.
    a_row_we_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_row_we |-> (r_state == B_EXEC && r_cmd.func == FUNC_INSERT))
        else $error("row write outside insert");

endmodule

// ===== src/flow_table_with_aging.sv =====
`timescale 1ns / 1ps
// An item passes the hash and bucket-modulo sequencer (hash, reciprocal, modulo,
// push), the request queue and the table engine (bucket read, update) before
// m_axis_tvalid rises; the sequencer takes a new input only after its last push.
// A sweep occupies the table engine with one bucket read and one valid write per
// bucket, unless now_time is below the TTL span. Reset: ttl_seconds returns to 300 and
// a clearing pass over every bucket zeroes the valid bits, with s_axis_tready low.
module flow_table_with_aging #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [fta_pkg::TTL_W-1:0] i_cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // src_port[15:0], is_udp[16], addr_family[24:17], dst_addr_hi[88:25],
    // dst_addr_lo[152:89], dst_port[168:153], proc_id[200:169], now_time[263:201]
    input  logic [263:0]              s_axis_tdata,
    // func[1:0]
    input  logic [1:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // out_family[7:0], out_addr_hi[71:8], out_addr_lo[135:72], out_port[151:136],
    // out_proc[183:152]
    output logic [183:0]              m_axis_tdata,
    // status[1:0]
    output logic [1:0]                m_axis_tuser
);
    import fta_pkg::*;

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int QW    = BKT_W + CMD_W;

    logic [TTL_W-1:0] r_ttl;
    t_cmd             w_cmd;
    logic             w_q_push;
    logic [QW-1:0]    w_q_wdata;
    logic             w_q_full;
    logic             w_q_pop;
    logic [QW-1:0]    w_q_rdata;
    logic             w_q_empty;
    logic             w_busy;
    t_status          w_status;
    t_result          w_result;

    // Lifetime register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= TTL_RESET;
        end else if (i_cfg_we) begin
            r_ttl <= i_cfg_wdata;
        end
    end

    // Unpack the input transfer.
    assign w_cmd.func    = t_func'(s_axis_tuser);
    assign w_cmd.key     = {s_axis_tdata[15:0], s_axis_tdata[16]};
    assign w_cmd.fam     = s_axis_tdata[24:17];
    assign w_cmd.ahi     = s_axis_tdata[88:25];
    assign w_cmd.alo     = s_axis_tdata[152:89];
    assign w_cmd.dport   = s_axis_tdata[168:153];
    assign w_cmd.proc_id = s_axis_tdata[200:169];
    assign w_cmd.now     = s_axis_tdata[263:201];

    fta_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_enable   (!w_busy),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_cmd      (w_cmd),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_wdata),
        .i_q_full   (w_q_full)
    );

    fta_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    fta_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ttl        (r_ttl),
        .i_q_empty    (w_q_empty),
        .i_q_data     (w_q_rdata),
        .o_q_pop      (w_q_pop),
        .o_busy       (w_busy),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (w_status),
        .o_out_data   (w_result)
    );

    assign m_axis_tdata = w_result;
    assign m_axis_tuser = w_status;

endmodule
